@@ rtl/core/imaenc_pkg.sv @@
// Constants and table functions shared by the IMA ADPCM encoder.
`default_nettype none

package imaenc_pkg;

  // Field widths
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CodeWidth   = 4;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned PosWidth    = 7;
  localparam int unsigned StepWidth   = 15;

  // Limits of the step position and of the predictor
  localparam logic [PosWidth-1:0] PosMax  = 7'd88;
  localparam logic signed [17:0]  PredMin = -18'sd32768;
  localparam logic signed [17:0]  PredMax = 18'sd32767;

  // Code bit that carries the sign of the difference
  localparam int unsigned SignBit = 3;

  typedef logic [StepWidth-1:0] step_t;
  typedef logic [CodeWidth-1:0] code_t;

  // Standard IMA step size table; positions beyond the end read the last entry.
  function automatic step_t step_lookup(input logic [PosWidth-1:0] pos);
    step_t s;
    unique case (pos)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Step position movement, indexed by the three magnitude bits of a code.
  function automatic logic signed [7:0] move_lookup(input logic [2:0] mag_bits);
    logic signed [7:0] m;
    unique case (mag_bits)
      3'd4:    m = 8'sd2;
      3'd5:    m = 8'sd4;
      3'd6:    m = 8'sd6;
      3'd7:    m = 8'sd8;
      default: m = -8'sd1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ima_adpcm_encoder_top.sv @@
// IMA ADPCM 4-bit encoder with two codes packed into each output byte.
`default_nettype none

// The encoder takes one signed 16-bit PCM sample per request on the slave
// stream and produces one byte for every two samples on the master stream,
// the earlier code in the high nibble. A sample marked with tlast flushes a
// pending half byte: at an odd position it leaves as a byte whose low nibble
// is zero. Samples are taken into an input register and encoded, once the
// output register is free or emptying, by a single pass through the quantiser,
// predictor rebuild and step table, straight into the output register; a new
// sample can be accepted in every cycle while the master side takes bytes, so
// the sustained rate is then one sample per clock. The rate is set by the
// predictor and step position loop, which closes within the encoding stage.
// Back-pressure on the master side holds the encoding stage, and the input
// register then fills and lowers s_axis_tready.
module ima_adpcm_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream; tdata: pcm_sample[15:0]; tlast: last_sample
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // Master stream; tdata: packed_byte[7:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata
);
  import imaenc_pkg::*;

  // Input register
  logic                   in_valid_q;
  logic [SampleWidth-1:0] sample_q;
  logic                   last_q;

  // Encoder state
  logic signed [SampleWidth-1:0] pred_q, pred_d;
  logic [PosWidth-1:0]           pos_q, pos_d;
  code_t                         held_q;
  logic                          half_q;

  // Output register
  logic                 out_valid_q;
  logic [ByteWidth-1:0] byte_q;

  logic advance;
  logic in_take;

  // The encoding stage moves whenever the output register is free or emptying.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Quantiser and predictor rebuild
  logic [PosWidth-1:0] pos_eff;
  step_t               step;
  logic signed [16:0]  diff;
  logic [16:0]         mag0, mag1, mag2;
  logic [16:0]         step_x, half_x, quart_x;
  code_t               code;
  logic [16:0]         recon;
  logic signed [17:0]  pred_sum;
  logic signed [7:0]   pos_sum;

  always_comb begin
    pos_eff = (pos_q > PosMax) ? PosMax : pos_q;
    step    = step_lookup(pos_eff);
    step_x  = {2'b00, step};
    half_x  = {3'b000, step[StepWidth-1:1]};
    quart_x = {4'b0000, step[StepWidth-1:2]};

    diff = {sample_q[SampleWidth-1], sample_q} - {pred_q[SampleWidth-1], pred_q};
    code = '0;
    code[SignBit] = diff[16];
    mag0 = diff[16] ? 17'(-diff) : 17'(diff);

    // Three successive compare and subtract steps give the magnitude bits.
    if (mag0 >= step_x) begin
      code[2] = 1'b1;
      mag1    = mag0 - step_x;
    end else begin
      mag1    = mag0;
    end
    if (mag1 >= half_x) begin
      code[1] = 1'b1;
      mag2    = mag1 - half_x;
    end else begin
      mag2    = mag1;
    end
    code[0] = (mag2 >= quart_x);

    recon = {5'b00000, step[StepWidth-1:3]};
    if (code[2]) recon = recon + step_x;
    if (code[1]) recon = recon + half_x;
    if (code[0]) recon = recon + quart_x;

    // Predictor update with saturation to the sample range.
    if (code[SignBit]) begin
      pred_sum = 18'(pred_q) - $signed({1'b0, recon});
    end else begin
      pred_sum = 18'(pred_q) + $signed({1'b0, recon});
    end
    if (pred_sum < PredMin) begin
      pred_d = PredMin[SampleWidth-1:0];
    end else if (pred_sum > PredMax) begin
      pred_d = PredMax[SampleWidth-1:0];
    end else begin
      pred_d = pred_sum[SampleWidth-1:0];
    end

    // Step position update, held within the table.
    pos_sum = $signed({1'b0, pos_eff}) + move_lookup(code[2:0]);
    if (pos_sum < 0) begin
      pos_d = '0;
    end else if (pos_sum > $signed({1'b0, PosMax})) begin
      pos_d = PosMax;
    end else begin
      pos_d = pos_sum[PosWidth-1:0];
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= s_axis_tdata;
      last_q   <= s_axis_tlast;
    end
  end

  // Encoder state and nibble pairing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      pos_q  <= '0;
      held_q <= '0;
      half_q <= 1'b0;
    end else if (advance) begin
      pred_q <= pred_d;
      pos_q  <= pos_d;
      if (half_q) begin
        half_q <= 1'b0;
        held_q <= '0;
      end else if (!last_q) begin
        half_q <= 1'b1;
        held_q <= code;
      end
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= half_q || last_q;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: a completed pair, or a lone code padded with zeros.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (half_q) begin
        byte_q <= {held_q, code};
      end else begin
        byte_q <= {code, 4'b0000};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = byte_q;

endmodule

`default_nettype wire

@@ tb/ima_adpcm_encoder_top_tb.sv @@
// Self-checking testbench for the IMA ADPCM encoder with packed byte output.
`timescale 1ns / 100ps

module ima_adpcm_encoder_top_tb;

  // One sample request on the slave stream
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } sample_req_t;

  localparam int PosMax       = 88;
  localparam int PredLow      = -32768;
  localparam int PredHigh     = 32767;
  localparam int SignBit      = 3;
  localparam int PhaseItems   = 200;
  localparam int PressureMark = 450;
  localparam int HoldCycles   = 64;
  localparam int DrainCycles  = 8;

  // Standard IMA step sizes, one per step position
  localparam int StepSizes[PosMax+1] = '{
    7, 8, 9, 10, 11, 12, 13, 14, 16, 17,
    19, 21, 23, 25, 28, 31, 34, 37, 41, 45,
    50, 55, 60, 66, 73, 80, 88, 97, 107, 118,
    130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
    337, 371, 408, 449, 494, 544, 598, 658, 724, 796,
    876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
    2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358,
    5894, 6484, 7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899,
    15289, 16818, 18500, 20350, 22385, 24623, 27086, 29794, 32767
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  sample_req_t pending_samples[$];
  logic [7:0]  expected_bytes[$];
  sample_req_t drive_req;

  // Encoder state mirrored by the testbench
  int          pred_value;
  int          step_pos;
  logic [3:0]  held_code;
  logic        code_pending;

  int send_idle_pct = 26;
  int recv_idle_pct = 72;
  int error_count   = 0;
  int samples_taken = 0;
  int bytes_seen    = 0;
  int padded_bytes  = 0;
  int clamp_count   = 0;
  int top_step_pos  = 0;
  int hold_left;
  logic hold_done;

  ima_adpcm_encoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Encodes one sample against the mirrored state and queues any byte it completes.
  function automatic void encode_sample(input logic [15:0] raw, input logic last);
    int sample;
    int step;
    int diff;
    int recon;
    int next_pos;
    logic [3:0] code;
    sample = $signed(raw);
    step   = StepSizes[step_pos];
    diff   = sample - pred_value;
    code   = '0;
    if (diff < 0) begin
      code[SignBit] = 1'b1;
      diff = -diff;
    end
    if (diff >= step) begin
      code[2] = 1'b1;
      diff -= step;
    end
    if (diff >= (step >> 1)) begin
      code[1] = 1'b1;
      diff -= step >> 1;
    end
    if (diff >= (step >> 2)) code[0] = 1'b1;

    // Rebuild the predictor the way a decoder would, then saturate it.
    recon = step >> 3;
    if (code[2]) recon += step;
    if (code[1]) recon += step >> 1;
    if (code[0]) recon += step >> 2;
    pred_value = code[SignBit] ? pred_value - recon : pred_value + recon;
    if (pred_value < PredLow) begin
      pred_value = PredLow;
      clamp_count++;
    end
    if (pred_value > PredHigh) begin
      pred_value = PredHigh;
      clamp_count++;
    end

    // Small codes step down by one; large codes step up by 2, 4, 6 or 8.
    next_pos = step_pos + (code[2] ? 2 * int'(code[1:0]) + 2 : -1);
    if (next_pos < 0) next_pos = 0;
    if (next_pos > PosMax) next_pos = PosMax;
    step_pos = next_pos;
    if (step_pos > top_step_pos) top_step_pos = step_pos;

    // Pair codes into bytes; a last sample at an odd position is padded.
    if (code_pending) begin
      expected_bytes.push_back({held_code, code});
      code_pending = 1'b0;
      held_code    = '0;
    end else if (last) begin
      expected_bytes.push_back({code, 4'h0});
      padded_bytes++;
    end else begin
      held_code    = code;
      code_pending = 1'b1;
    end
  endfunction

  task automatic push_sample(input logic [15:0] sample, input logic last);
    pending_samples.push_back('{sample: sample, last: last});
  endtask

  // Random samples: mostly smooth audio-like walks, with noise and extremes mixed in.
  task automatic push_random(input int count);
    int prev;
    int span;
    int kind;
    int val;
    prev = 0;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        case ($urandom_range(2))
          0:       span = 16;
          1:       span = 256;
          default: span = 4096;
        endcase
        val = prev + $urandom_range(2 * span) - span;
        if (val < PredLow) val = PredLow;
        if (val > PredHigh) val = PredHigh;
      end else if (kind <= 7) begin
        val = $signed(16'($urandom));
      end else if (kind == 8) begin
        case ($urandom_range(2))
          0:       val = PredHigh;
          1:       val = PredLow;
          default: val = 0;
        endcase
      end else begin
        val = prev;
      end
      prev = val;
      push_sample(16'(val), ($urandom_range(9) == 0) || (i == count - 1));
    end
  endtask

  // Sample driver: offers the next pending request, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= drive_req.sample;
        s_axis_tlast  <= drive_req.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Byte receiver: random stalls, plus one long hold-off to back the encoder up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && samples_taken >= PressureMark) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each byte against the oldest expectation, then predicts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_seen <= bytes_seen + 1;
        if (expected_bytes.size() == 0) begin
          $error("packed_byte %02h arrived with no expectation waiting", m_axis_tdata);
          error_count++;
        end else if (m_axis_tdata !== expected_bytes[0]) begin
          $error("packed_byte mismatch: expected %02h, actual %02h",
                 expected_bytes[0], m_axis_tdata);
          error_count++;
          void'(expected_bytes.pop_front());
        end else begin
          void'(expected_bytes.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        samples_taken <= samples_taken + 1;
        encode_sample(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    pred_value   = 0;
    step_pos     = 0;
    held_code    = '0;
    code_pending = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A lone last sample is padded; a last sample completing a pair is not.
    push_sample(16'h0000, 1'b1);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b1);
    // Full-scale swings drive the step position to its top and clamp the predictor.
    for (int i = 0; i < 12; i++) push_sample(i[0] ? 16'h8000 : 16'h7FFF, i == 11);
    push_sample(16'h7FFF, 1'b1);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h0000, 1'b1);
    // An unterminated odd buffer leaves a code held that pairs with the next sample.
    push_sample(16'h5555, 1'b0);
    push_random(PhaseItems);
    while (pending_samples.size() != 0) @(negedge clk_i);

    send_idle_pct = 72;
    recv_idle_pct = 26;
    push_random(PhaseItems);
    while (pending_samples.size() != 0) @(negedge clk_i);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(PhaseItems);
    while (pending_samples.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_bytes.size() != 0) error_count++;
    $display("Encoded %0d samples into %0d bytes, %0d padded by a last sample.",
             samples_taken, bytes_seen, padded_bytes);
    $display("Step position peaked at %0d; the predictor saturated %0d times.",
             top_step_pos, clamp_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
